@@ src/pftl_pkg.sv @@
// pftl_pkg: shared types and constants for the packed field threshold table entry core
// register index codes, field widths and configuration reset values
// no dependencies
package pftl_pkg;

  // field and register widths
  localparam int LWE_W      = 17;
  localparam int LOG_W      = 5;
  localparam int FB_W       = 5;
  localparam int CNT_W      = 5;
  localparam int THR_W      = 32;
  localparam int IDX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LWE_MODULUS    = 3'd0,
    CFG_MODULUS_LOG2   = 3'd1,
    CFG_FIELD_BITS     = 3'd2,
    CFG_FIELD_COUNT    = 3'd3,
    CFG_THRESHOLD_WORD = 3'd4
  } cfg_reg_t;

  // configuration reset values
  localparam logic [LWE_W-1:0] RST_LWE_MODULUS    = 17'd1024;
  localparam logic [LOG_W-1:0] RST_MODULUS_LOG2   = 5'd2;
  localparam logic [FB_W-1:0]  RST_FIELD_BITS     = 5'd2;
  localparam logic [CNT_W-1:0] RST_FIELD_COUNT    = 5'd1;
  localparam logic [THR_W-1:0] RST_THRESHOLD_WORD = 32'd0;

endpackage

@@ src/packed_field_threshold_lut_entry_core.sv @@
// packed_field_threshold_lut_entry_core: one table entry per index, uses pftl_pkg
// result path: the accepted item passes through the input register, one restoring divider
// stage per quotient bit, the field compare register and the output register
// throughput: one item per cycle; busy is high only in the cycle after reset
// reset: synchronous active low, clears valid bits, sets busy and loads configuration defaults
module packed_field_threshold_lut_entry_core #(
  parameter int MSG_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command input
  input  logic                              start,
  output logic                              busy,
  input  logic [pftl_pkg::IDX_W-1:0]        in_table_index,
  // results
  output logic                              out_valid,
  output logic [pftl_pkg::LWE_W-1:0]        out_entry_value,
  output logic                              out_above_flag,
  output logic                              out_out_of_range,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [pftl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pftl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int MW    = $clog2(MSG_BITS + 1);
  localparam int POS_W = $clog2(MSG_BITS * 32);
  localparam int REM_W = pftl_pkg::LWE_W;

  // configuration registers
  logic [pftl_pkg::LWE_W-1:0] lwe_modulus_r;
  logic [pftl_pkg::LOG_W-1:0] modulus_log2_r;
  logic [pftl_pkg::FB_W-1:0]  field_bits_r;
  logic [pftl_pkg::CNT_W-1:0] field_count_r;
  logic [pftl_pkg::THR_W-1:0] threshold_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lwe_modulus_r    <= pftl_pkg::RST_LWE_MODULUS;
      modulus_log2_r   <= pftl_pkg::RST_MODULUS_LOG2;
      field_bits_r     <= pftl_pkg::RST_FIELD_BITS;
      field_count_r    <= pftl_pkg::RST_FIELD_COUNT;
      threshold_word_r <= pftl_pkg::RST_THRESHOLD_WORD;
    end else if (cfg_we) begin
      case (pftl_pkg::cfg_reg_t'(cfg_index))
        pftl_pkg::CFG_LWE_MODULUS:    lwe_modulus_r    <= cfg_wdata[pftl_pkg::LWE_W-1:0];
        pftl_pkg::CFG_MODULUS_LOG2:   modulus_log2_r   <= cfg_wdata[pftl_pkg::LOG_W-1:0];
        pftl_pkg::CFG_FIELD_BITS:     field_bits_r     <= cfg_wdata[pftl_pkg::FB_W-1:0];
        pftl_pkg::CFG_FIELD_COUNT:    field_count_r    <= cfg_wdata[pftl_pkg::CNT_W-1:0];
        pftl_pkg::CFG_THRESHOLD_WORD: threshold_word_r <= cfg_wdata[pftl_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // derived settings; the user must keep them stable while items are in flight, the block does not enforce it
  logic [MW-1:0]              m_eff;
  logic [pftl_pkg::FB_W-1:0]  fb_eff;
  logic [pftl_pkg::THR_W-1:0] field_mask;
  logic [pftl_pkg::LWE_W-1:0] scale;

  assign m_eff      = (int'(modulus_log2_r) > MSG_BITS) ? MW'(MSG_BITS) : MW'(modulus_log2_r);
  assign fb_eff     = (field_bits_r == '0) ? pftl_pkg::FB_W'(1) : field_bits_r;
  assign field_mask = (pftl_pkg::THR_W'(1) << fb_eff) - pftl_pkg::THR_W'(1);
  assign scale      = lwe_modulus_r >> m_eff;

  // busy only right after reset
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  logic in_accept;
  assign in_accept = start && !busy_r;

  // divider pipeline: index 0 is the input register, stage j+1 makes quotient bit j
  logic [REM_W-1:0]    rem_r [0:MSG_BITS];
  logic [MSG_BITS-1:0] quo_r [0:MSG_BITS];
  logic                dv_vld_r [0:MSG_BITS];
  logic                dv_oor_r [0:MSG_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= in_accept;
    end
    rem_r[0]    <= REM_W'(in_table_index);
    quo_r[0]    <= '0;
    dv_oor_r[0] <= ({1'b0, in_table_index} >= lwe_modulus_r);
  end

  for (genvar j = 0; j < MSG_BITS; j++) begin : g_div
    logic [REM_W:0]      rem2;
    logic                ge;
    logic                active;
    logic [REM_W-1:0]    rem_nxt;
    logic [MSG_BITS-1:0] quo_nxt;

    // one restoring step while j is below m_eff: shift in a zero, subtract the modulus if it fits; else pass through
    always_comb begin
      rem2   = {rem_r[j], 1'b0};
      ge     = rem2 >= {1'b0, lwe_modulus_r};
      active = MW'(j) < m_eff;
      if (active) begin
        rem_nxt = ge ? REM_W'(rem2 - {1'b0, lwe_modulus_r}) : REM_W'(rem2);
        quo_nxt = {quo_r[j][MSG_BITS-2:0], ge};
      end else begin
        rem_nxt = rem_r[j];
        quo_nxt = quo_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
      rem_r[j+1]    <= rem_nxt;
      quo_r[j+1]    <= quo_nxt;
      dv_oor_r[j+1] <= dv_oor_r[j];
    end
  end

  // field compare lanes: lane k looks at field k of the message
  logic [MSG_BITS-1:0]        message;
  logic [POS_W-1:0]           lane_pos [MSG_BITS];
  logic [pftl_pkg::THR_W-1:0] lane_field [MSG_BITS];
  logic [pftl_pkg::THR_W-1:0] lane_thr [MSG_BITS];
  logic [MSG_BITS-1:0]        lane_gt;

  assign message = quo_r[MSG_BITS];

  always_comb begin
    for (int k = 0; k < MSG_BITS; k++) begin
      lane_pos[k]   = POS_W'(k * int'(fb_eff));
      lane_field[k] = pftl_pkg::THR_W'((64'(message) >> lane_pos[k]) & 64'(field_mask));
      lane_thr[k]   = pftl_pkg::THR_W'((64'(threshold_word_r) >> lane_pos[k])
                                        & 64'(field_mask));
      lane_gt[k]    = (k < int'(field_count_r)) && (lane_field[k] > lane_thr[k]);
    end
  end

  logic [MSG_BITS-1:0] cmp_gt_r;
  logic                cmp_vld_r;
  logic                cmp_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= dv_vld_r[MSG_BITS];
    end
    cmp_gt_r  <= lane_gt;
    cmp_oor_r <= dv_oor_r[MSG_BITS];
  end

  // output register
  logic                       flag_nxt;
  logic [pftl_pkg::LWE_W-1:0] entry_nxt;
  logic                       out_valid_r;
  logic [pftl_pkg::LWE_W-1:0] entry_r;
  logic                       flag_r;
  logic                       oor_r;

  assign flag_nxt  = (|cmp_gt_r) && !cmp_oor_r;
  assign entry_nxt = flag_nxt ? scale : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmp_vld_r;
    end
    entry_r <= entry_nxt;
    flag_r  <= flag_nxt;
    oor_r   <= cmp_oor_r;
  end

  assign out_valid        = out_valid_r;
  assign out_entry_value  = entry_r;
  assign out_above_flag   = flag_r;
  assign out_out_of_range = oor_r;

  // checks
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> dv_vld_r[0])
    else $error("accepted item not captured");

  a_cmp_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |=> out_valid_r)
    else $error("compared item lost before output");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !cmp_vld_r |=> !out_valid_r)
    else $error("result strobe without an item");

  a_oor_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (!out_above_flag && out_entry_value == '0))
    else $error("out of range item carries a flag or entry");

  a_no_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_above_flag) |-> (out_entry_value == '0))
    else $error("entry nonzero without flag");

endmodule
